// ===== design/jddm_pkg.sv =====
// shared types and constants for the joystick differential drive mixer
// no dependencies; imported by every module and interface of the block

package jddm_pkg;

  localparam int AXIS_W  = 10;
  localparam int MAG_W   = 10;
  localparam int BAND_W  = 9;
  localparam int COEF_W  = 4;
  localparam int WEIGHT_W = 8;
  localparam int PROD_W  = MAG_W + COEF_W;
  localparam int SPEED_W = 11;
  localparam int OUT_SPEED_W = 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [AXIS_W-1:0] CENTER = AXIS_W'(512);

  // reciprocal of ten in 16 fraction bits, exact for products below 16384
  localparam int RECIP_SHIFT = 16;
  localparam logic [12:0] RECIP_TEN = 13'd6554;

  // scaling by weight / 512
  localparam int SCALE_SHIFT = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_DEAD_BAND_X    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEAD_BAND_Y    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_COEF      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_MAX     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSED_MODE  = 3'd4;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;

  localparam logic [7:0] FLAG_LEFT_FWD   = 8'h01;
  localparam logic [7:0] FLAG_LEFT_BACK  = 8'h02;
  localparam logic [7:0] FLAG_RIGHT_FWD  = 8'h04;
  localparam logic [7:0] FLAG_RIGHT_BACK = 8'h08;
  localparam logic [7:0] FLAG_REVERSED   = 8'h80;

  typedef struct packed {
    logic [BAND_W-1:0]   dead_band_x;
    logic [BAND_W-1:0]   dead_band_y;
    logic [COEF_W-1:0]   turn_coef;
    logic [WEIGHT_W-1:0] weight_max;
    logic                reversed;
  } cfg_t;

  // after centering and zone sort
  typedef struct packed {
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic left;
    logic right;
    logic fwd;
    logic back;
  } zone_t;

  // after min and coefficient product
  typedef struct packed {
    logic [MAG_W-1:0]  ay;
    logic [MAG_W-1:0]  ay_minus_r;
    logic [PROD_W-1:0] prod;
    logic left;
    logic right;
    logic fwd;
    logic back;
  } blend_t;

  // unscaled wheel speeds
  typedef struct packed {
    logic [SPEED_W-1:0] ls;
    logic [SPEED_W-1:0] rs;
    logic fwd;
    logic back;
  } speed_t;

endpackage

// ===== design/jddm_in_if.sv =====
// joystick sample channel: valid, ready and both axes
// depends on jddm_pkg

interface jddm_in_if import jddm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AXIS_W-1:0] joy_x;
  logic [AXIS_W-1:0] joy_y;

  modport source (output valid, joy_x, joy_y, input ready);
  modport sink   (input valid, joy_x, joy_y, output ready);
endinterface

// ===== design/jddm_out_if.sv =====
// wheel command channel: valid, ready and the mixed result word
// depends on jddm_pkg

interface jddm_out_if import jddm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OUT_SPEED_W-1:0] left_speed;
  logic [1:0]             left_dir;
  logic [OUT_SPEED_W-1:0] right_speed;
  logic [1:0]             right_dir;
  logic                   reversed_out;
  logic [7:0]             direction_flags;

  modport source (output valid, left_speed, left_dir, right_speed, right_dir,
                  reversed_out, direction_flags, input ready);
  modport sink   (input valid, left_speed, left_dir, right_speed, right_dir,
                  reversed_out, direction_flags, output ready);
endinterface

// ===== design/jddm_cfg_if.sv =====
// register write channel: valid, ready, register index and data
// depends on jddm_pkg

interface jddm_cfg_if import jddm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/jddm_zone.sv =====
// first stage: centers both axes, takes magnitudes and sorts into zones
// depends on jddm_pkg

module jddm_zone import jddm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [AXIS_W-1:0] joy_x,
  input  logic [AXIS_W-1:0] joy_y,
  input  cfg_t              cfg,
  output logic              out_valid,
  output zone_t             out_word
);

  logic [MAG_W-1:0] ax;
  logic [MAG_W-1:0] ay;
  logic             x_neg;
  logic             y_neg;
  logic             x_out;
  logic             y_out;
  zone_t            word_next;

  always_comb begin
    // below center when the top bit is clear
    x_neg = ~joy_x[AXIS_W-1];
    y_neg = ~joy_y[AXIS_W-1];
    ax = x_neg ? MAG_W'(CENTER - joy_x) : {1'b0, joy_x[AXIS_W-2:0]};
    ay = y_neg ? MAG_W'(CENTER - joy_y) : {1'b0, joy_y[AXIS_W-2:0]};
    x_out = ax > {1'b0, cfg.dead_band_x};
    y_out = ay > {1'b0, cfg.dead_band_y};
    word_next.ax    = ax;
    word_next.ay    = ay;
    word_next.left  = x_out & x_neg;
    word_next.right = x_out & ~x_neg;
    word_next.fwd   = y_out & ~y_neg;
    word_next.back  = y_out & y_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

// ===== design/jddm_blend.sv =====
// second and third stages: turn reduction product, divide by ten,
// inner and outer wheel speeds with clamp at zero
// depends on jddm_pkg

module jddm_blend import jddm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  zone_t  in_word,
  input  cfg_t   cfg,
  output logic   out_valid,
  output speed_t out_word
);

  logic             mid_valid;
  blend_t           mid;
  blend_t           mid_next;
  logic [MAG_W-1:0] r;

  logic [PROD_W+12:0] recip_prod;
  logic [SPEED_W-1:0] d;
  logic [SPEED_W-1:0] inner;
  logic [SPEED_W-1:0] outer;
  speed_t             word_next;

  always_comb begin
    r = (in_word.ax < in_word.ay) ? in_word.ax : in_word.ay;
    mid_next.ay         = in_word.ay;
    mid_next.ay_minus_r = in_word.ay - r;
    mid_next.prod       = PROD_W'(r) * PROD_W'(cfg.turn_coef);
    mid_next.left       = in_word.left;
    mid_next.right      = in_word.right;
    mid_next.fwd        = in_word.fwd;
    mid_next.back       = in_word.back;
  end

  always_comb begin
    recip_prod = (PROD_W+13)'(mid.prod) * (PROD_W+13)'(RECIP_TEN);
    d = SPEED_W'(recip_prod >> RECIP_SHIFT);
    inner = SPEED_W'(mid.ay_minus_r) + d;
    // outer wheel can go negative when the coefficient passes ten
    outer = (d > SPEED_W'(mid.ay)) ? '0 : SPEED_W'(mid.ay) - d;
    word_next.fwd  = mid.fwd;
    word_next.back = mid.back;
    if (!(mid.fwd || mid.back)) begin
      word_next.ls = '0;
      word_next.rs = '0;
    end else if (mid.left) begin
      word_next.ls = inner;
      word_next.rs = outer;
    end else if (mid.right) begin
      word_next.ls = outer;
      word_next.rs = inner;
    end else begin
      word_next.ls = SPEED_W'(mid.ay);
      word_next.rs = SPEED_W'(mid.ay);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid      <= mid_next;
      out_word <= word_next;
    end
  end

endmodule

// ===== design/jddm_scale.sv =====
// last stage: weight scaling with saturation, directions and flag byte,
// feeding the output register
// depends on jddm_pkg

module jddm_scale import jddm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  speed_t in_word,
  input  cfg_t   cfg,
  jddm_out_if.source result
);

  logic [SPEED_W+WEIGHT_W-1:0]  lprod;
  logic [SPEED_W+WEIGHT_W-1:0]  rprod;
  logic [SPEED_W+WEIGHT_W-10:0] lq;
  logic [SPEED_W+WEIGHT_W-10:0] rq;
  logic [OUT_SPEED_W-1:0]       lsp;
  logic [OUT_SPEED_W-1:0]       rsp;
  logic [1:0]                   dir;
  logic [7:0]                   flags;

  always_comb begin
    lprod = (SPEED_W+WEIGHT_W)'(in_word.ls) * (SPEED_W+WEIGHT_W)'(cfg.weight_max);
    rprod = (SPEED_W+WEIGHT_W)'(in_word.rs) * (SPEED_W+WEIGHT_W)'(cfg.weight_max);
    lq = lprod[SPEED_W+WEIGHT_W-1:SCALE_SHIFT];
    rq = rprod[SPEED_W+WEIGHT_W-1:SCALE_SHIFT];
    lsp = (lq > (SPEED_W+WEIGHT_W-9)'(255)) ? '1 : lq[OUT_SPEED_W-1:0];
    rsp = (rq > (SPEED_W+WEIGHT_W-9)'(255)) ? '1 : rq[OUT_SPEED_W-1:0];
    dir = in_word.fwd ? DIR_FWD : (in_word.back ? DIR_BACK : DIR_STOP);
    flags = '0;
    if (in_word.fwd) begin
      flags = flags | FLAG_LEFT_FWD | FLAG_RIGHT_FWD;
    end
    if (in_word.back) begin
      flags = flags | FLAG_LEFT_BACK | FLAG_RIGHT_BACK;
    end
    if (cfg.reversed) begin
      flags = flags | FLAG_REVERSED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.left_speed      <= lsp;
      result.right_speed     <= rsp;
      result.left_dir        <= dir;
      result.right_dir       <= dir;
      result.reversed_out    <= cfg.reversed;
      result.direction_flags <= flags;
    end
  end

endmodule

// ===== design/joystick_differential_drive_mixer.sv =====
// Joystick differential-drive mixer: one joystick sample word in, one wheel
// command word out. The block is a four-stage pipeline (zone sort, turn
// product, divide-by-ten and wheel blend, weight scaling into the output
// register), and each result is offered from the output register. One
// sample is taken every cycle while results drain. When
// a result word waits on the result channel the whole pipeline holds and
// sample ready drops. The register port is always ready; writes take effect
// at once and belong in idle periods. Register indexes: 0 dead_band_x,
// 1 dead_band_y, 2 turn_coefficient, 3 weight_max, 4 reversed_mode; others
// are ignored.

module joystick_differential_drive_mixer import jddm_pkg::*; (
  input  logic clk,
  input  logic rst,
  jddm_in_if.sink    sample,
  jddm_out_if.source result,
  jddm_cfg_if.sink   cfg
);

  cfg_t   regs;
  logic   en;
  logic   zone_valid;
  zone_t  zone_word;
  logic   speed_valid;
  speed_t speed_word;

  // whole pipe advances unless the output word is waiting
  assign en           = ~result.valid | result.ready;
  assign sample.ready = en;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dead_band_x <= BAND_W'(32);
      regs.dead_band_y <= BAND_W'(32);
      regs.turn_coef   <= '0;
      regs.weight_max  <= WEIGHT_W'(255);
      regs.reversed    <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DEAD_BAND_X:   regs.dead_band_x <= cfg.data[BAND_W-1:0];
        REG_DEAD_BAND_Y:   regs.dead_band_y <= cfg.data[BAND_W-1:0];
        REG_TURN_COEF:     regs.turn_coef   <= cfg.data[COEF_W-1:0];
        REG_WEIGHT_MAX:    regs.weight_max  <= cfg.data[WEIGHT_W-1:0];
        REG_REVERSED_MODE: regs.reversed    <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  jddm_zone u_zone (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample.valid),
    .joy_x     (sample.joy_x),
    .joy_y     (sample.joy_y),
    .cfg       (regs),
    .out_valid (zone_valid),
    .out_word  (zone_word)
  );

  jddm_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (zone_valid),
    .in_word   (zone_word),
    .cfg       (regs),
    .out_valid (speed_valid),
    .out_word  (speed_word)
  );

  jddm_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (speed_valid),
    .in_word  (speed_word),
    .cfg      (regs),
    .result   (result)
  );

endmodule

// ===== test/joystick_differential_drive_mixer_tb.sv =====
// self-checking bench for the joystick differential drive mixer: drives joystick
// words, predicts each wheel command word and compares it on the result channel
// depends on jddm_pkg, the three channel interfaces and joystick_differential_drive_mixer

module joystick_differential_drive_mixer_tb import jddm_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TENTHS       = 10;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 170;

  // index with no register behind it, writes must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [OUT_SPEED_W-1:0] left_speed;
    logic [1:0]             left_dir;
    logic [OUT_SPEED_W-1:0] right_speed;
    logic [1:0]             right_dir;
    logic                   reversed_out;
    logic [7:0]             direction_flags;
  } wheel_cmd_t;

  typedef struct packed {
    logic [AXIS_W-1:0] joy_x;
    logic [AXIS_W-1:0] joy_y;
    wheel_cmd_t        cmd;
  } pending_cmd_t;

  logic clk;
  logic rst;

  jddm_in_if  sample_ch ();
  jddm_out_if result_ch ();
  jddm_cfg_if cfg_ch ();

  joystick_differential_drive_mixer dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  cfg_t mixer_regs = '{dead_band_x: 9'd32, dead_band_y: 9'd32, turn_coef: 4'd0,
                       weight_max: 8'd255, reversed: 1'b0};
  pending_cmd_t expected_cmds[$];
  int err_count = 0;
  int cycle_count = 0;
  bit send_gap_en = 1'b1;
  bit recv_stall_en = 1'b1;
  int long_hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[joystick_differential_drive_mixer] ERROR");
    $finish;
  end

  function automatic logic [OUT_SPEED_W-1:0] weight_scale(int v);
    int s;
    if (v < 0) v = 0;
    s = (v * int'(mixer_regs.weight_max)) / (1 << SCALE_SHIFT);
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  function automatic wheel_cmd_t mix_wheels(logic [AXIS_W-1:0] jx, logic [AXIS_W-1:0] jy);
    int x, y, bx, by, ax, ay, r, d, ls, rs;
    logic [1:0] dir;
    wheel_cmd_t c;
    x = int'(jx) - int'(CENTER);
    y = int'(jy) - int'(CENTER);
    bx = int'(mixer_regs.dead_band_x);
    by = int'(mixer_regs.dead_band_y);
    ls = 0;
    rs = 0;
    dir = DIR_STOP;
    // spin zones fall through with zero speed and stop
    if (y > by || y < -by) begin
      ay = (y < 0) ? -y : y;
      dir = (y > by) ? DIR_FWD : DIR_BACK;
      if (x < -bx || x > bx) begin
        ax = (x < 0) ? -x : x;
        r = (ax < ay) ? ax : ay;
        d = (r * int'(mixer_regs.turn_coef)) / TENTHS;
        // wheel on the stick's side is the inner one
        if (x < -bx) begin
          ls = ay - (r - d);
          rs = ay - d;
        end else begin
          ls = ay - d;
          rs = ay - (r - d);
        end
      end else begin
        ls = ay;
        rs = ay;
      end
    end
    c.left_speed = weight_scale(ls);
    c.right_speed = weight_scale(rs);
    c.left_dir = dir;
    c.right_dir = dir;
    c.reversed_out = mixer_regs.reversed;
    c.direction_flags = 8'h00;
    if (dir == DIR_FWD) c.direction_flags = FLAG_LEFT_FWD | FLAG_RIGHT_FWD;
    if (dir == DIR_BACK) c.direction_flags = FLAG_LEFT_BACK | FLAG_RIGHT_BACK;
    if (mixer_regs.reversed) c.direction_flags = c.direction_flags | FLAG_REVERSED;
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= 100) $display("mismatch: %s", msg);
  endtask

  // shadow copy of the register file
  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_DEAD_BAND_X:   mixer_regs.dead_band_x = cfg_ch.data[BAND_W-1:0];
        REG_DEAD_BAND_Y:   mixer_regs.dead_band_y = cfg_ch.data[BAND_W-1:0];
        REG_TURN_COEF:     mixer_regs.turn_coef = cfg_ch.data[COEF_W-1:0];
        REG_WEIGHT_MAX:    mixer_regs.weight_max = cfg_ch.data[WEIGHT_W-1:0];
        REG_REVERSED_MODE: mixer_regs.reversed = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready)
      expected_cmds.push_back('{joy_x: sample_ch.joy_x, joy_y: sample_ch.joy_y,
                                cmd: mix_wheels(sample_ch.joy_x, sample_ch.joy_y)});
  end

  always @(posedge clk) begin : check_results
    pending_cmd_t want;
    wheel_cmd_t got;
    string tag;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = '{left_speed: result_ch.left_speed, left_dir: result_ch.left_dir,
              right_speed: result_ch.right_speed, right_dir: result_ch.right_dir,
              reversed_out: result_ch.reversed_out,
              direction_flags: result_ch.direction_flags};
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("word with no sample pending, flags %02h",
                                  got.direction_flags));
      end else begin
        want = expected_cmds.pop_front();
        tag = $sformatf("joy_x %0d joy_y %0d", want.joy_x, want.joy_y);
        if (got.left_speed !== want.cmd.left_speed)
          report_mismatch($sformatf("left_speed %0d, expected %0d, %s",
                                    got.left_speed, want.cmd.left_speed, tag));
        if (got.left_dir !== want.cmd.left_dir)
          report_mismatch($sformatf("left_dir %0d, expected %0d, %s",
                                    got.left_dir, want.cmd.left_dir, tag));
        if (got.right_speed !== want.cmd.right_speed)
          report_mismatch($sformatf("right_speed %0d, expected %0d, %s",
                                    got.right_speed, want.cmd.right_speed, tag));
        if (got.right_dir !== want.cmd.right_dir)
          report_mismatch($sformatf("right_dir %0d, expected %0d, %s",
                                    got.right_dir, want.cmd.right_dir, tag));
        if (got.reversed_out !== want.cmd.reversed_out)
          report_mismatch($sformatf("reversed_out %0d, expected %0d, %s",
                                    got.reversed_out, want.cmd.reversed_out, tag));
        if (got.direction_flags !== want.cmd.direction_flags)
          report_mismatch($sformatf("direction_flags %02h, expected %02h, %s",
                                    got.direction_flags, want.cmd.direction_flags, tag));
      end
    end
  end

  // result side: random stall bursts plus an optional long hold-off
  initial begin : result_sink
    int stall_left;
    logic ready_next;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (long_hold_req != 0) begin
        stall_left = long_hold_req - 1;
        long_hold_req = 0;
        ready_next = 1'b0;
      end else if (recv_stall_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      result_ch.ready <= ready_next;
    end
  end

  // valid stays high between back-to-back words, dropped only for a gap
  task automatic send_sample(input logic [AXIS_W-1:0] jx, input logic [AXIS_W-1:0] jy);
    int gap;
    if (send_gap_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.joy_x <= jx;
    sample_ch.joy_y <= jy;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper data bits carry junk, the block must mask them
  task automatic program_regs(int bx, int by, int coef, int wmax, int rev);
    wait_drained();
    write_reg(REG_DEAD_BAND_X, 9'(bx));
    write_reg(REG_DEAD_BAND_Y, 9'(by));
    write_reg(REG_TURN_COEF, {5'($urandom), 4'(coef)});
    write_reg(REG_WEIGHT_MAX, {1'($urandom), 8'(wmax)});
    write_reg(REG_REVERSED_MODE, {8'($urandom), 1'(rev)});
  endtask

  task automatic program_random_regs();
    int bx, by, wmax;
    bx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 96);
    by = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 96);
    case ($urandom_range(0, 5))
      0: wmax = 0;
      1: wmax = 255;
      default: wmax = $urandom_range(0, 255);
    endcase
    program_regs(bx, by, $urandom_range(0, 15), wmax, $urandom_range(0, 1));
  endtask

  // uniform values, values around the dead-band edges, and the rails
  function automatic logic [AXIS_W-1:0] pick_axis(int band);
    int v, off;
    off = $urandom_range(0, 4);
    case ($urandom_range(0, 5))
      0, 1, 2: v = $urandom_range(0, 1023);
      3: v = 512 + band + off - 2;
      4: v = 512 - band + off - 2;
      default: v = $urandom_range(0, 1) ? $urandom_range(0, 2) : 1023 - $urandom_range(0, 2);
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[AXIS_W-1:0];
  endfunction

  task automatic send_random();
    send_sample(pick_axis(int'(mixer_regs.dead_band_x)),
                pick_axis(int'(mixer_regs.dead_band_y)));
  endtask

  task automatic test_directed();
    // reset settings: bands 32, no blend, full weight
    send_sample(10'd512, 10'd512);
    send_sample(10'd0, 10'd0);
    send_sample(10'd1023, 10'd1023);
    send_sample(10'd0, 10'd1023);
    send_sample(10'd1023, 10'd0);
    send_sample(10'd512, 10'd1023);
    send_sample(10'd512, 10'd0);
    // spin zones
    send_sample(10'd0, 10'd512);
    send_sample(10'd1023, 10'd512);
    // on and just past the dead-band edges
    send_sample(10'd512, 10'd544);
    send_sample(10'd512, 10'd545);
    send_sample(10'd512, 10'd480);
    send_sample(10'd512, 10'd479);
    send_sample(10'd544, 10'd1023);
    send_sample(10'd545, 10'd1023);
    send_sample(10'd480, 10'd0);
    send_sample(10'd479, 10'd0);
    // blend above ten speeds up the inner wheel and saturates
    program_regs(0, 0, 15, 255, 1);
    send_sample(10'd1023, 10'd1023);
    send_sample(10'd0, 10'd1023);
    send_sample(10'd513, 10'd511);
    // widest bands and zero weight
    program_regs(511, 511, 10, 0, 0);
    write_reg(REG_UNMAPPED, 9'h1FF);
    send_sample(10'd0, 10'd0);
    send_sample(10'd1023, 10'd1023);
    send_sample(10'd1, 10'd1);
    // blend of exactly ten stops the outer slowdown at zero
    program_regs(0, 0, 10, 128, 0);
    send_sample(10'd0, 10'd1023);
    send_sample(10'd1023, 10'd0);
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      send_gap_en = (phase % 3 != 2);
      recv_stall_en = ($urandom_range(0, 3) != 0);
      case (phase)
        0: program_regs(0, 0, 0, 255, 0);
        1: program_regs(511, 511, 15, 0, 1);
        2: program_regs(32, 32, 10, 255, 1);
        default: program_random_regs();
      endcase
      repeat (PHASE_ITEMS) send_random();
    end
  endtask

  task automatic test_backpressure();
    program_random_regs();
    send_gap_en = 1'b0;
    recv_stall_en = 1'b0;
    long_hold_req = 80;
    repeat (60) send_random();
    // sender holds until every word is back
    wait_drained();
    repeat (40) send_random();
  endtask

  task automatic test_full_rate();
    send_gap_en = 1'b0;
    recv_stall_en = 1'b0;
    program_random_regs();
    repeat (125) send_random();
    program_random_regs();
    repeat (125) send_random();
  endtask

  initial begin
    rst <= 1'b1;
    sample_ch.valid <= 1'b0;
    sample_ch.joy_x <= '0;
    sample_ch.joy_y <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_settings();
    test_backpressure();
    test_full_rate();

    wait_drained();
    if (err_count == 0 && expected_cmds.size() == 0)
      $display("[joystick_differential_drive_mixer] OK");
    else
      $display("[joystick_differential_drive_mixer] ERROR");
    $finish;
  end

endmodule
